>>> rtl/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and codes for the moving average crossover unit.
// ----------------------------------------------------------------------------
package mac_pkg;

	// Running totals and cross products
	localparam int TOTAL_BITS = 64;
	localparam int CNT_BITS   = 9;
	localparam int PROD_BITS  = TOTAL_BITS + CNT_BITS;

	// Configuration register widths and indexes
	localparam int FAST_LEN_BITS  = 8;
	localparam int SLOW_LEN_BITS  = 9;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 9;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_LENGTH = 1'b1;

	// Trade signal codes
	localparam logic [1:0] SIG_HOLD = 2'd0;
	localparam logic [1:0] SIG_BUY  = 2'd1;
	localparam logic [1:0] SIG_SELL = 2'd2;

	// Position codes
	localparam logic [1:0] POS_FLAT  = 2'd0;
	localparam logic [1:0] POS_LONG  = 2'd1;
	localparam logic [1:0] POS_SHORT = 2'd2;

	// Result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;

	// Per-word control carried down the pipeline
	typedef struct packed {
		logic                start;
		logic                bad;
		logic                first;
		logic                use_fast;
		logic                use_slow;
		logic [CNT_BITS-1:0] fcount;
		logic [CNT_BITS-1:0] scount;
	} stage_ctl_t;

	typedef struct packed {
		logic [1:0] sig;
		logic       invalid;
	} result_t;

endpackage

>>> rtl/moving_average_crossover_unit.sv
// ----------------------------------------------------------------------------
// moving_average_crossover_unit
// Simple moving average crossover: ring of prices in a synchronous memory,
// fast and slow running totals, exact cross-multiplied compare.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   price, series_start
//  out       out_valid / out_ready trade_signal, config_invalid
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One input word per cycle while in_ready is high; each accepted word passes
//  through memory read, total update, cross products and compare in order.
//  History write and both history reads happen at the acceptance edge, so
//  no entry is read before an earlier word has written it.
//  Results wait in an eight-entry queue; in_ready drops only when queue and
//  pipeline together would overflow it. cfg_ready is always high.
//  Reset clears totals, counters, pointer and position; the history memory
//  is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module moving_average_crossover_unit #(
	parameter int MAX_LENGTH = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [PRICE_BITS-1:0]                  price,
	input  logic                                   series_start,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             trade_signal,
	output logic                                   config_invalid,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mac_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [mac_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int CW = ((AW > mac_pkg::CNT_BITS) ? AW : mac_pkg::CNT_BITS) + 2;
	localparam int NB = mac_pkg::CNT_BITS + 1;
	localparam int QC = mac_pkg::OQ_AW + 1;

	// Configuration registers
	logic [mac_pkg::FAST_LEN_BITS-1:0] fast_length_q;
	logic [mac_pkg::SLOW_LEN_BITS-1:0] slow_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_length_q <= mac_pkg::FAST_LEN_BITS'(5);
			slow_length_q <= mac_pkg::SLOW_LEN_BITS'(20);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mac_pkg::REG_FAST_LENGTH: fast_length_q <= cfg_data[mac_pkg::FAST_LEN_BITS-1:0];
				mac_pkg::REG_SLOW_LENGTH: slow_length_q <= cfg_data[mac_pkg::SLOW_LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- accept
	logic                            in_acc;
	logic [mac_pkg::CNT_BITS-1:0]    samples_q, samples_eff, samples_nx;
	logic [AW-1:0]                   wp_q, wp_eff, wp_nx;
	logic                            bad;
	logic [CW-1:0]                   wp_ext, fl_ext, sl_ext, fa_full, sa_full;
	logic [AW-1:0]                   fast_addr, slow_addr;
	logic [NB-1:0]                   n_cnt;
	mac_pkg::stage_ctl_t             ctl_s0;

	assign in_acc      = in_valid & in_ready;
	assign samples_eff = series_start ? '0 : samples_q;
	assign wp_eff      = series_start ? '0 : wp_q;

	assign bad = (fast_length_q == '0)
		|| (mac_pkg::SLOW_LEN_BITS'(fast_length_q) >= slow_length_q)
		|| (CW'(slow_length_q) > CW'(MAX_LENGTH));

	// Leaving entries sit fast_length and slow_length slots behind the pointer
	assign wp_ext  = CW'(wp_eff);
	assign fl_ext  = CW'(fast_length_q);
	assign sl_ext  = CW'(slow_length_q);
	assign fa_full = (wp_ext >= fl_ext) ? wp_ext - fl_ext : wp_ext + CW'(MAX_LENGTH) - fl_ext;
	assign sa_full = (wp_ext >= sl_ext) ? wp_ext - sl_ext : wp_ext + CW'(MAX_LENGTH) - sl_ext;
	assign fast_addr = fa_full[AW-1:0];
	assign slow_addr = sa_full[AW-1:0];

	assign wp_nx = (wp_eff == AW'(MAX_LENGTH - 1)) ? '0 : wp_eff + 1'b1;
	assign n_cnt = NB'(samples_eff) + NB'(1);

	always_comb begin
		ctl_s0.start    = series_start;
		ctl_s0.bad      = bad;
		ctl_s0.first    = (samples_eff == '0);
		ctl_s0.use_fast = samples_eff >= mac_pkg::CNT_BITS'(fast_length_q);
		ctl_s0.use_slow = samples_eff >= slow_length_q;
		ctl_s0.fcount   = (n_cnt < NB'(fast_length_q)) ? n_cnt[mac_pkg::CNT_BITS-1:0]
			: mac_pkg::CNT_BITS'(fast_length_q);
		ctl_s0.scount   = (n_cnt < NB'(slow_length_q)) ? n_cnt[mac_pkg::CNT_BITS-1:0]
			: slow_length_q;
		samples_nx      = samples_eff;
		if (!bad && (samples_eff < slow_length_q)) begin
			samples_nx = samples_eff + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
			wp_q      <= '0;
		end else if (in_acc) begin
			samples_q <= samples_nx;
			wp_q      <= bad ? wp_eff : wp_nx;
		end
	end

	// Price history: one write, two reads, read-first on a shared address
	logic [PRICE_BITS-1:0] hist_mem [MAX_LENGTH];
	logic [PRICE_BITS-1:0] rd_fast_s1, rd_slow_s1;

	always_ff @(posedge clk) begin
		if (in_acc && !bad) begin
			hist_mem[wp_eff] <= price;
		end
		rd_fast_s1 <= hist_mem[fast_addr];
		rd_slow_s1 <= hist_mem[slow_addr];
	end

	// ---------------------------------------------------------------- stage 1
	logic                                v_s1;
	logic [PRICE_BITS-1:0]               price_s1;
	mac_pkg::stage_ctl_t                 ctl_s1;
	logic [mac_pkg::TOTAL_BITS-1:0]      fast_total_q, slow_total_q;
	logic [mac_pkg::TOTAL_BITS-1:0]      fast_base, slow_base, fast_new, slow_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		price_s1 <= price;
		ctl_s1   <= ctl_s0;
	end

	always_comb begin
		fast_base = ctl_s1.start ? '0 : fast_total_q;
		slow_base = ctl_s1.start ? '0 : slow_total_q;
		fast_new  = fast_base;
		slow_new  = slow_base;
		if (!ctl_s1.bad) begin
			fast_new = fast_base + mac_pkg::TOTAL_BITS'(price_s1)
				- (ctl_s1.use_fast ? mac_pkg::TOTAL_BITS'(rd_fast_s1) : '0);
			slow_new = slow_base + mac_pkg::TOTAL_BITS'(price_s1)
				- (ctl_s1.use_slow ? mac_pkg::TOTAL_BITS'(rd_slow_s1) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_total_q <= '0;
			slow_total_q <= '0;
		end else if (v_s1) begin
			fast_total_q <= fast_new;
			slow_total_q <= slow_new;
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic                           v_s2, v_s3;
	mac_pkg::stage_ctl_t            ctl_s2, ctl_s3;
	logic [mac_pkg::PROD_BITS-1:0]  lhs_s3, rhs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Totals now hold this word's values; cross-multiply by the other count
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		ctl_s3 <= ctl_s2;
		lhs_s3 <= mac_pkg::PROD_BITS'(fast_total_q) * mac_pkg::PROD_BITS'(ctl_s2.scount);
		rhs_s3 <= mac_pkg::PROD_BITS'(slow_total_q) * mac_pkg::PROD_BITS'(ctl_s2.fcount);
	end

	// ---------------------------------------------------------------- stage 3
	logic             was_above_q, was_base, was_nx, above;
	logic [1:0]       holding_q, hold_base, hold_nx, sig;
	mac_pkg::result_t res_s3;

	always_comb begin
		above     = lhs_s3 > rhs_s3;
		was_base  = ctl_s3.start ? 1'b0 : was_above_q;
		hold_base = ctl_s3.start ? mac_pkg::POS_FLAT : holding_q;
		hold_nx   = hold_base;
		sig       = mac_pkg::SIG_HOLD;
		was_nx    = ctl_s3.bad ? was_base : above;
		if (!ctl_s3.bad && !ctl_s3.first) begin
			if (above && !was_base) begin
				if (hold_base != mac_pkg::POS_LONG) begin
					sig     = mac_pkg::SIG_BUY;
					hold_nx = mac_pkg::POS_LONG;
				end
			end else if (!above && was_base) begin
				if (hold_base != mac_pkg::POS_SHORT) begin
					sig     = mac_pkg::SIG_SELL;
					hold_nx = mac_pkg::POS_SHORT;
				end
			end
		end
		res_s3.sig     = sig;
		res_s3.invalid = ctl_s3.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_above_q <= 1'b0;
			holding_q   <= mac_pkg::POS_FLAT;
		end else if (v_s3) begin
			was_above_q <= was_nx;
			holding_q   <= hold_nx;
		end
	end

	// ---------------------------------------------------------------- result queue
	mac_pkg::result_t          oq_mem [mac_pkg::OQ_DEPTH];
	logic [mac_pkg::OQ_AW-1:0] oq_wr_q, oq_rd_q;
	logic [QC-1:0]             oq_count_q, in_flight;
	logic                      oq_pop;

	assign oq_pop    = out_valid & out_ready;
	assign out_valid = (oq_count_q != '0);
	assign trade_signal   = oq_mem[oq_rd_q].sig;
	assign config_invalid = oq_mem[oq_rd_q].invalid;

	// Hold off new words while queue plus pipeline could fill the queue
	assign in_flight = oq_count_q + QC'(v_s1) + QC'(v_s2) + QC'(v_s3);
	assign in_ready  = (in_flight < QC'(mac_pkg::OQ_DEPTH));

	always_ff @(posedge clk) begin
		if (v_s3) begin
			oq_mem[oq_wr_q] <= res_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (v_s3) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_count_q <= oq_count_q + QC'(v_s3) - QC'(oq_pop);
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the moving average crossover unit. Prices go in
// through the input handshake, trade signals come back through the output
// handshake and are matched in order against a cycle-free model of the
// running totals, the ring of prices and the position. A short directed table
// comes first, then trending random price series under several length pairs,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import mac_pkg::*;

	localparam int RING       = 256;
	localparam int HALF_CYCLE = 2;
	localparam int STALL_MAX  = 5000;

	typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_KNOWN} row_kind_t;

	// One line of the directed part: a length pair, or a price with an optional
	// hand-written result
	typedef struct packed {
		row_kind_t   kind;
		logic [8:0]  fast_w;
		logic [8:0]  slow_w;
		logic [31:0] px;
		logic        st;
		logic [1:0]  sig;
		logic        inv;
	} row_t;

	typedef struct packed {
		logic [8:0] fast_w;
		logic [8:0] slow_w;
		logic [9:0] words;
		logic       open_series;
		logic [7:0] start_odds;
	} phase_t;

	localparam int ROWS = 32;
	//                kind       fast     slow     price          start sig       inv
	localparam row_t DIRECTED [ROWS] = '{
		'{ROW_KNOWN, 9'd0,   9'd0,   32'hFFFF_FFFF, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h0000_0000, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h0000_0001, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd500,       1'b1, SIG_HOLD, 1'b0},
		// top bit of the fast word is dropped, so fast is 1 here
		'{ROW_CFG,   9'h101, 9'd2,   32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd10,        1'b1, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd20,        1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd30,        1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd5,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd3,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd50,        1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'hFFFF_FFFF, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h0000_0000, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'hFFFF_FFFF, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd7,         1'b1, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'd9,         1'b0, SIG_HOLD, 1'b0},
		// equal lengths
		'{ROW_CFG,   9'd2,   9'd2,   32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd5,         1'b0, SIG_HOLD, 1'b1},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd9,         1'b1, SIG_HOLD, 1'b1},
		// zero fast length
		'{ROW_CFG,   9'd0,   9'd2,   32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd11,        1'b0, SIG_HOLD, 1'b1},
		// slow window longer than the ring
		'{ROW_CFG,   9'd3,   9'd300, 32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'd13,        1'b0, SIG_HOLD, 1'b1},
		'{ROW_CFG,   9'd255, 9'd511, 32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'hAAAA_5555, 1'b1, SIG_HOLD, 1'b1},
		// widest usable windows
		'{ROW_CFG,   9'd255, 9'd256, 32'd0,         1'b0, SIG_HOLD, 1'b0},
		'{ROW_KNOWN, 9'd0,   9'd0,   32'hFFFF_FFFF, 1'b1, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h0000_0000, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'hFFFF_FFFF, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h55AA_AA55, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h0000_0002, 1'b0, SIG_HOLD, 1'b0},
		'{ROW_PRED,  9'd0,   9'd0,   32'h8000_0000, 1'b0, SIG_HOLD, 1'b0}
	};

	// Later phases mostly keep the series open, so lengths change mid-series
	localparam int PHASES = 10;
	localparam phase_t RANDOM_PLAN [PHASES] = '{
		'{9'd5,   9'd20,  10'd100, 1'b1, 8'd50},
		'{9'd1,   9'd2,   10'd100, 1'b0, 8'd40},
		'{9'd3,   9'd8,   10'd90,  1'b0, 8'd40},
		'{9'd10,  9'd12,  10'd70,  1'b0, 8'd40},
		'{9'd2,   9'd100, 10'd60,  1'b0, 8'd60},
		'{9'd8,   9'd8,   10'd8,   1'b0, 8'd0},
		'{9'd0,   9'd5,   10'd6,   1'b1, 8'd0},
		'{9'd4,   9'd400, 10'd6,   1'b0, 8'd0},
		'{9'd255, 9'd256, 10'd280, 1'b1, 8'd0},
		'{9'd7,   9'd31,  10'd80,  1'b1, 8'd30}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] price;
	logic        series_start;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  trade_signal;
	logic        config_invalid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// Model state
	logic [31:0] price_ring [RING];
	logic [63:0] fast_sum;
	logic [63:0] slow_sum;
	int unsigned seen;
	int unsigned ring_ptr;
	logic        fast_was_above;
	logic [1:0]  position;
	logic [7:0]  fast_len;
	logic [8:0]  slow_len;

	result_t     expected_signals [$];
	int          mismatches;
	int          words_sent;
	int          send_gap_pct;
	int          recv_stall_pct;
	int          quiet_cycles;
	longint      level;
	int          trend;

	moving_average_crossover_unit #(
		.MAX_LENGTH(RING),
		.PRICE_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.price(price),
		.series_start(series_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trade_signal(trade_signal),
		.config_invalid(config_invalid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #(HALF_CYCLE) clk = ~clk;

	function automatic void clear_series();
		fast_sum = '0;
		slow_sum = '0;
		seen = 0;
		ring_ptr = 0;
		fast_was_above = 1'b0;
		position = POS_FLAT;
	endfunction

	function automatic result_t predict_signal(input logic [31:0] px, input logic st);
		result_t     res;
		int unsigned fl;
		int unsigned sl;
		int unsigned n;
		int unsigned fcount;
		int unsigned scount;
		logic [31:0] leaving_fast;
		logic [31:0] leaving_slow;
		logic [72:0] fast_cross;
		logic [72:0] slow_cross;
		logic        first;
		logic        above;
		res.sig = SIG_HOLD;
		res.invalid = 1'b0;
		if (st)
			clear_series();
		if (fast_len == 0 || fast_len >= slow_len || slow_len > RING) begin
			res.invalid = 1'b1;
			return res;
		end
		fl = fast_len;
		sl = slow_len;
		first = (seen == 0);
		leaving_fast = '0;
		leaving_slow = '0;
		// read the leaving prices before the slot is overwritten
		if (seen >= fl)
			leaving_fast = price_ring[(ring_ptr + RING - fl) % RING];
		if (seen >= sl)
			leaving_slow = price_ring[(ring_ptr + RING - sl) % RING];
		fast_sum = fast_sum + px - leaving_fast;
		slow_sum = slow_sum + px - leaving_slow;
		price_ring[ring_ptr] = px;
		ring_ptr = (ring_ptr + 1) % RING;
		n = seen + 1;
		fcount = (n < fl) ? n : fl;
		scount = (n < sl) ? n : sl;
		if (seen < sl)
			seen = seen + 1;
		fast_cross = fast_sum * scount;
		slow_cross = slow_sum * fcount;
		above = (fast_cross > slow_cross);
		if (!first) begin
			if (above && !fast_was_above) begin
				if (position != POS_LONG) begin
					res.sig = SIG_BUY;
					position = POS_LONG;
				end
			end else if (!above && fast_was_above) begin
				if (position != POS_SHORT) begin
					res.sig = SIG_SELL;
					position = POS_SHORT;
				end
			end
		end
		fast_was_above = above;
		return res;
	endfunction

	task automatic log_mismatch(input string what, input result_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected signal %0d invalid %0b, got signal %0d invalid %0b",
				$realtime, what, want.sig, want.invalid, trade_signal, config_invalid);
	endtask

	// Result side: check each word taken, then decide whether to stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_signals.size() == 0) begin
					log_mismatch("result with nothing outstanding", '0);
				end else begin
					if (trade_signal !== expected_signals[0].sig ||
						config_invalid !== expected_signals[0].invalid)
						log_mismatch("result mismatch", expected_signals[0]);
					void'(expected_signals.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: reset the count on any word moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic update_idling();
		if (words_sent < 280) begin
			send_gap_pct = 10;
			recv_stall_pct = 45;
		end else if (words_sent < 560) begin
			send_gap_pct = 45;
			recv_stall_pct = 10;
		end else begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	task automatic send_price(input logic [31:0] px, input logic st, input logic known,
			input result_t want);
		result_t pred;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		price <= px;
		series_start <= st;
		do @(posedge clk); while (!in_ready);
		pred = predict_signal(px, st);
		expected_signals.insert(expected_signals.size(), known ? want : pred);
		words_sent++;
		update_idling();
	endtask

	// Drain everything, then give the pipeline its latency before touching config
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_signals.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lengths(input logic [8:0] fast_w, input logic [8:0] slow_w);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FAST_LENGTH;
		cfg_data <= fast_w;
		do @(posedge clk); while (!cfg_ready);
		fast_len = fast_w[7:0];
		cfg_index <= REG_SLOW_LENGTH;
		cfg_data <= slow_w;
		do @(posedge clk); while (!cfg_ready);
		slow_len = slow_w;
		cfg_valid <= 1'b0;
	endtask

	task automatic reseed_level();
		if ($urandom_range(3) == 0)
			level = longint'($urandom());
		else
			level = longint'($urandom_range(2000000, 1000));
	endtask

	// Trending walk with occasional jumps to the extremes or anywhere
	task automatic next_price(output logic [31:0] px);
		int pick;
		int stride;
		int jitter;
		pick = $urandom_range(99);
		stride = $urandom_range(120);
		jitter = $urandom_range(60);
		if ($urandom_range(24) == 0)
			trend = -trend;
		level = level + trend * stride + jitter - 30;
		if (level < 0)
			level = 0;
		if (level > longint'(32'hFFFF_FFFF))
			level = longint'(32'hFFFF_FFFF);
		if (pick < 3)
			px = '0;
		else if (pick < 6)
			px = '1;
		else if (pick < 14)
			px = $urandom();
		else
			px = level[31:0];
	endtask

	initial begin
		logic [31:0] px;
		logic        st;
		result_t     want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		price = '0;
		series_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FAST_LENGTH;
		cfg_data = '0;
		mismatches = 0;
		words_sent = 0;
		quiet_cycles = 0;
		level = 1000000;
		trend = 1;
		foreach (price_ring[k])
			price_ring[k] = '0;
		clear_series();
		fast_len = 8'd5;
		slow_len = 9'd20;
		update_idling();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				wait_idle();
				write_lengths(DIRECTED[r].fast_w, DIRECTED[r].slow_w);
			end else begin
				want.sig = DIRECTED[r].sig;
				want.invalid = DIRECTED[r].inv;
				send_price(DIRECTED[r].px, DIRECTED[r].st, DIRECTED[r].kind == ROW_KNOWN, want);
			end
		end

		foreach (RANDOM_PLAN[p]) begin
			wait_idle();
			write_lengths(RANDOM_PLAN[p].fast_w, RANDOM_PLAN[p].slow_w);
			for (int i = 0; i < RANDOM_PLAN[p].words; i++) begin
				st = (i == 0 && RANDOM_PLAN[p].open_series) ||
					(RANDOM_PLAN[p].start_odds != 0 &&
					$urandom_range(RANDOM_PLAN[p].start_odds - 1) == 0);
				if (st)
					reseed_level();
				next_price(px);
				send_price(px, st, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
